// ===== design/icmprc_pkg.sv =====
// Package for the ICMP probe reply classifier: item structs, ICMP and
// IP constants, verdict codes and field offsets. No dependencies.
`default_nettype none
package icmprc_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1500;

  localparam logic [7:0]  TYPE_TIME_EXCEEDED    = 8'd11;
  localparam logic [7:0]  CODE_IN_TRANSIT       = 8'd0;
  localparam logic [7:0]  TYPE_UNREACHABLE      = 8'd3;
  localparam logic [7:0]  CODE_PORT_UNREACHABLE = 8'd3;
  localparam logic [7:0]  PROTO_UDP             = 8'd17;
  localparam logic [15:0] DEFAULT_BASE_PORT     = 16'd33434;

  // byte offsets relative to the start of the ICMP message; SRC_ADDR_LO/HI are from packet start
  localparam int OFS_CODE      = 1;
  localparam int OFS_INNER_IHL = 8;
  localparam int OFS_PROTO     = 17;
  localparam int ICMP_MIN_LEN  = 8;
  localparam int QUOTE_MIN_LEN = 28;
  localparam int PORTS_TAIL    = 12;
  localparam int SRC_ADDR_LO   = 12;
  localparam int SRC_ADDR_HI   = 15;

  typedef enum logic {
    REG_SOURCE_PORT    = 1'b0,
    REG_BASE_DEST_PORT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_NONE        = 2'd0,
    VERDICT_TIME_EXC    = 2'd1,
    VERDICT_PORT_UNR    = 2'd2,
    VERDICT_OTHER_UNR   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] probe_seq;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  reply_code;
    logic [31:0] responder_addr;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  outer_hdr;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [5:0]  inner_hdr;
    logic [7:0]  inner_proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] exp_dst_port;
    logic [31:0] sender_addr;
  } pkt_fields_t;

endpackage
`default_nettype wire

// ===== design/icmprc_capture.sv =====
// Position-based field capture for one packet byte per cycle while enabled.
// Holds the packet state registers; uses icmprc_pkg.
`default_nettype none
module icmprc_capture #(
  parameter int MAX_PACKET_BYTES = icmprc_pkg::MAX_PACKET_BYTES_DEF,
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire icmprc_pkg::in_item_t   item,
  input  wire logic [15:0]            base_dest_port,
  output icmprc_pkg::pkt_fields_t     fields,
  output logic [POS_W-1:0]            pkt_len
);

  localparam int SUM_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic [POS_W-1:0]        pos_r, pos_nxt;
  icmprc_pkg::pkt_fields_t fld_r, fld_nxt, fld_base;
  logic                    cap, start;
  logic [SUM_W-1:0]        p, h1, ports;
  logic [7:0]              b;

  always_comb begin
    b     = item.data_byte;
    cap   = (pos_r != POS_MAX);
    start = cap && (pos_r == '0);
    p     = SUM_W'(pos_r);

    fld_base = fld_r;
    if (start) begin
      fld_base              = '0;
      fld_base.outer_hdr    = {b[3:0], 2'b00};
      fld_base.exp_dst_port = base_dest_port + item.probe_seq;
    end

    fld_nxt = fld_base;
    h1 = SUM_W'(fld_base.outer_hdr);
    if (cap) begin
      if (pos_r inside {[icmprc_pkg::SRC_ADDR_LO:icmprc_pkg::SRC_ADDR_HI]})
        fld_nxt.sender_addr = {fld_base.sender_addr[23:0], b};
      if (p == h1)
        fld_nxt.msg_type = b;
      if (p == h1 + SUM_W'(icmprc_pkg::OFS_CODE))
        fld_nxt.msg_code = b;
      if (p == h1 + SUM_W'(icmprc_pkg::OFS_INNER_IHL))
        fld_nxt.inner_hdr = {b[3:0], 2'b00};
      if (p == h1 + SUM_W'(icmprc_pkg::OFS_PROTO))
        fld_nxt.inner_proto = b;
    end
    ports = h1 + SUM_W'(icmprc_pkg::OFS_INNER_IHL) + SUM_W'(fld_nxt.inner_hdr);
    if (cap) begin
      if (p == ports)
        fld_nxt.src_port[15:8] = b;
      if (p == ports + SUM_W'(1))
        fld_nxt.src_port[7:0] = b;
      if (p == ports + SUM_W'(2))
        fld_nxt.dst_port[15:8] = b;
      if (p == ports + SUM_W'(3))
        fld_nxt.dst_port[7:0] = b;
    end

    pkt_len = cap ? pos_r + POS_W'(1) : pos_r;
    pos_nxt = item.last_byte ? '0 : pkt_len;
    fields  = fld_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fld_r <= '0;
    end else if (en) begin
      pos_r <= pos_nxt;
      fld_r <= fld_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/icmprc_decide.sv =====
// Verdict logic: length checks, ICMP type/code and quoted UDP port match.
// Combinational on the post-capture fields; uses icmprc_pkg.
`default_nettype none
module icmprc_decide #(
  parameter int MAX_PACKET_BYTES = icmprc_pkg::MAX_PACKET_BYTES_DEF,
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  wire icmprc_pkg::pkt_fields_t fields,
  input  wire logic [POS_W-1:0]        pkt_len,
  input  wire logic [15:0]             source_port,
  output icmprc_pkg::out_item_t        result
);

  localparam int SUM_W = POS_W + 1;

  logic [SUM_W-1:0] len, h1;
  logic             too_short, quote_short, texc, unr, match;
  icmprc_pkg::verdict_t v;

  always_comb begin
    len = SUM_W'(pkt_len);
    h1  = SUM_W'(fields.outer_hdr);
    too_short   = len < h1 + SUM_W'(icmprc_pkg::ICMP_MIN_LEN);
    quote_short = (len < h1 + SUM_W'(icmprc_pkg::QUOTE_MIN_LEN)) ||
                  (len < h1 + SUM_W'(icmprc_pkg::PORTS_TAIL) + SUM_W'(fields.inner_hdr));
    texc  = (fields.msg_type == icmprc_pkg::TYPE_TIME_EXCEEDED) &&
            (fields.msg_code == icmprc_pkg::CODE_IN_TRANSIT);
    unr   = (fields.msg_type == icmprc_pkg::TYPE_UNREACHABLE);
    match = (fields.inner_proto == icmprc_pkg::PROTO_UDP) &&
            (fields.src_port == source_port) &&
            (fields.dst_port == fields.exp_dst_port);

    if (too_short || !(texc || unr) || quote_short || !match)
      v = icmprc_pkg::VERDICT_NONE;
    else if (texc)
      v = icmprc_pkg::VERDICT_TIME_EXC;
    else if (fields.msg_code == icmprc_pkg::CODE_PORT_UNREACHABLE)
      v = icmprc_pkg::VERDICT_PORT_UNR;
    else
      v = icmprc_pkg::VERDICT_OTHER_UNR;

    result.verdict = v;
    if (v == icmprc_pkg::VERDICT_NONE) begin
      result.reply_code     = '0;
      result.responder_addr = '0;
    end else begin
      result.reply_code     = fields.msg_code;
      result.responder_addr = fields.sender_addr;
    end
  end

endmodule
`default_nettype wire

// ===== design/icmp_probe_reply_classifier.sv =====
// ICMP probe reply classifier: one packet byte per item, one verdict per packet.
// Throughput one byte per cycle unless a last byte waits for a full result register;
// each byte waits in the input register, and when a last byte leaves it its verdict
// goes into the result register and out_valid rises. Result register decouples stalls.
// Synchronous active-low reset clears packet state, source_port to 0 and
// base_dest_port to 33434. Uses icmprc_pkg, icmprc_capture, icmprc_decide.
`default_nettype none
module icmp_probe_reply_classifier #(
  parameter int MAX_PACKET_BYTES = icmprc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire icmprc_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output icmprc_pkg::out_item_t      out_data,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_wdata
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic                    s1_valid_r;
  icmprc_pkg::in_item_t    s1_item_r;
  logic                    s1_go;
  logic                    out_valid_r;
  icmprc_pkg::out_item_t   out_data_r, result;
  logic [15:0]             src_port_r, base_port_r;
  icmprc_pkg::pkt_fields_t fields;
  logic [POS_W-1:0]        pkt_len;

  assign s1_go     = s1_valid_r && (!s1_item_r.last_byte || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_port_r  <= '0;
      base_port_r <= icmprc_pkg::DEFAULT_BASE_PORT;
    end else if (cfg_we) begin
      case (cfg_index)
        icmprc_pkg::REG_SOURCE_PORT:    src_port_r  <= cfg_wdata;
        icmprc_pkg::REG_BASE_DEST_PORT: base_port_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  icmprc_capture #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (s1_go),
    .item           (s1_item_r),
    .base_dest_port (base_port_r),
    .fields         (fields),
    .pkt_len        (pkt_len)
  );

  icmprc_decide #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_decide (
    .fields      (fields),
    .pkt_len     (pkt_len),
    .source_port (src_port_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.last_byte) begin
      out_data_r <= result;
    end
  end

endmodule
`default_nettype wire
